// File: src/hrt_pkg.sv
// ---------------------------------------------------------------------------
// hrt_pkg
// Shared types and constants of the handshake retransmit tracker.
// ---------------------------------------------------------------------------
package hrt_pkg;

  localparam int TableDepthDefault = 16;
  localparam logic [15:0] RtoFloor = 16'd1000;

  // operations
  localparam logic [1:0] OpSend  = 2'd0;
  localparam logic [1:0] OpAck   = 2'd1;
  localparam logic [1:0] OpCheck = 2'd2;

  // result kinds
  localparam logic [2:0] KindSent      = 3'd0;
  localparam logic [2:0] KindRefused   = 3'd1;
  localparam logic [2:0] KindAckDone   = 3'd2;
  localparam logic [2:0] KindRetx      = 3'd3;
  localparam logic [2:0] KindFailed    = 3'd4;
  localparam logic [2:0] KindCheckDone = 3'd5;

  // configuration register indexes
  localparam logic [1:0] RegInitTimeout = 2'd0;
  localparam logic [1:0] RegMaxTimeout  = 2'd1;
  localparam logic [1:0] RegMaxRetries  = 2'd2;
  localparam logic [1:0] RegMaxInFlight = 2'd3;

  typedef enum logic [2:0] {
    StIdle, StScan, StPick, StUpdate, StEmit, StFree
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture request, clear marks, start scan
    logic scan;      // evaluate mark of slot at scan index, advance
    logic pick;      // find min over marks (one slot per cycle)
    logic apply;     // apply ack/backoff to picked slot
    logic send;      // perform send into table
    logic free;      // free all acked slots
    logic emit;      // load output register
    logic [2:0] kind;
    logic use_seq;   // output carries picked sequence
    logic out_last;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] op;
    logic scan_done;
    logic pick_done;
    logic found;
    logic full;
    logic retry_out;
    logic out_busy;
  } status_t;

endpackage

// File: src/hrt_ctrl.sv
// ---------------------------------------------------------------------------
// hrt_ctrl
// Controller of the retransmit tracker: sequences scan, pick and update.
// ---------------------------------------------------------------------------
module hrt_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  hrt_pkg::status_t st,
  output hrt_pkg::cmd_t    cmd
);

  hrt_pkg::state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hrt_pkg::StIdle;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    unique case (state)
      hrt_pkg::StIdle: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = hrt_pkg::StScan;
        end
      end
      hrt_pkg::StScan: begin
        cmd.scan = 1'b1;
        if (st.scan_done) begin
          if (st.op == hrt_pkg::OpSend) state_next = hrt_pkg::StEmit;
          else if (st.op == hrt_pkg::OpAck || st.op == hrt_pkg::OpCheck)
            state_next = hrt_pkg::StPick;
          else state_next = hrt_pkg::StIdle;
        end
      end
      hrt_pkg::StPick: begin
        cmd.pick = 1'b1;
        if (st.pick_done) state_next = hrt_pkg::StUpdate;
      end
      hrt_pkg::StUpdate: begin
        if (!st.found) begin
          if (st.op == hrt_pkg::OpAck) state_next = hrt_pkg::StFree;
          else state_next = hrt_pkg::StEmit;
        end else if (st.op == hrt_pkg::OpAck) begin
          cmd.apply = 1'b1;
          state_next = hrt_pkg::StPick;
        end else if (!st.out_busy) begin
          cmd.emit = 1'b1;
          cmd.use_seq = 1'b1;
          if (st.retry_out) begin
            cmd.kind = hrt_pkg::KindFailed;
            cmd.out_last = 1'b1;
            state_next = hrt_pkg::StIdle;
          end else begin
            cmd.apply = 1'b1;
            cmd.kind = hrt_pkg::KindRetx;
            state_next = hrt_pkg::StPick;
          end
        end
      end
      hrt_pkg::StFree: begin
        cmd.free = 1'b1;
        state_next = hrt_pkg::StEmit;
      end
      hrt_pkg::StEmit: begin
        if (!st.out_busy) begin
          cmd.emit = 1'b1;
          cmd.out_last = 1'b1;
          state_next = hrt_pkg::StIdle;
          unique case (st.op)
            hrt_pkg::OpSend: begin
              if (st.full) begin
                cmd.kind = hrt_pkg::KindRefused;
              end else begin
                cmd.kind = hrt_pkg::KindSent;
                cmd.send = 1'b1;
              end
            end
            hrt_pkg::OpAck: cmd.kind = hrt_pkg::KindAckDone;
            default: cmd.kind = hrt_pkg::KindCheckDone;
          endcase
        end
      end
      default: state_next = hrt_pkg::StIdle;
    endcase
  end

endmodule

// File: src/hrt_datapath.sv
// ---------------------------------------------------------------------------
// hrt_datapath
// Slot table, RTT estimator and output register of the retransmit tracker.
// ---------------------------------------------------------------------------
module hrt_datapath #(
  parameter int TABLE_DEPTH = hrt_pkg::TableDepthDefault
) (
  input  logic             clk,
  input  logic             rst,
  input  hrt_pkg::cmd_t    cmd,
  output hrt_pkg::status_t st,
  input  logic [103:0]     in_tdata,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [15:0]      cfg_data,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [55:0]      out_tdata,
  output logic             out_tlast
);

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  // configuration
  logic [15:0] max_to;
  logic [7:0]  max_retries;
  logic [4:0]  max_in_flight;

  // table
  logic [TABLE_DEPTH-1:0] slot_valid, mark;
  logic [31:0] slot_sequence [TABLE_DEPTH];
  logic [31:0] slot_sent_at  [TABLE_DEPTH];
  logic [15:0] slot_timeout  [TABLE_DEPTH];
  logic [7:0]  slot_retries  [TABLE_DEPTH];

  // slots acknowledged during this item
  logic [TABLE_DEPTH-1:0] mark_acked;

  // estimator
  logic [31:0] next_sequence;
  logic [15:0] srtt, rttvar, rto;

  // captured request
  logic [1:0]  op;
  logic [31:0] now, rs, re;
  logic        is_ack;

  // scan and pick
  logic [IW:0] idx;
  logic [CW-1:0] count;
  logic          seq_hit;
  logic [IW-1:0] hit_slot, free_slot;
  logic          free_found;
  logic          best_ok;
  logic [IW-1:0] best;
  logic [4:0]    acked;

  logic [IW-1:0] ix;
  assign ix = idx[IW-1:0];

  logic [31:0] age_i, age_b;
  assign age_i = now - slot_sent_at[ix];
  assign age_b = now - slot_sent_at[best];

  logic mark_i;
  always_comb begin
    if (op == hrt_pkg::OpAck)
      mark_i = slot_valid[ix] && re >= rs && slot_sequence[ix] >= rs &&
               slot_sequence[ix] <= re;
    else
      mark_i = slot_valid[ix] && age_i >= {16'd0, slot_timeout[ix]};
  end

  logic [4:0] limit;
  assign limit = (max_in_flight > 5'(TABLE_DEPTH > 31 ? 31 : TABLE_DEPTH))
               ? 5'(TABLE_DEPTH > 31 ? 31 : TABLE_DEPTH) : max_in_flight;

  // status
  always_comb begin
    st.op        = op;
    st.scan_done = (idx == (IW+1)'(TABLE_DEPTH - 1));
    st.pick_done = (idx == (IW+1)'(TABLE_DEPTH - 1));
    st.found     = best_ok;
    st.full      = ({{(32-CW){1'b0}}, count} >= {27'd0, limit});
    st.retry_out = slot_retries[best] >= max_retries;
    st.out_busy  = out_tvalid && !out_tready;
  end

  // estimator arithmetic on the picked slot
  logic [15:0] rtt;
  assign rtt = (age_b > 32'd65535) ? 16'hFFFF : age_b[15:0];
  logic [15:0] diff, var_n, srtt_n;
  logic [18:0] sum;
  logic [15:0] rto_n;
  always_comb begin
    diff = (srtt > rtt) ? srtt - rtt : rtt - srtt;
    if (srtt == 16'd0) begin
      srtt_n = rtt;
      var_n  = rtt >> 1;
    end else begin
      var_n  = 16'(({2'b0, rttvar} * 18'd3 + {2'b0, diff}) >> 2);
      srtt_n = 16'(({3'b0, srtt} * 19'd7 + {3'b0, rtt}) >> 3);
    end
    sum = {3'b0, srtt_n} + {1'b0, var_n, 2'b0};
    if (sum < {3'b0, hrt_pkg::RtoFloor}) sum = {3'b0, hrt_pkg::RtoFloor};
    if (sum > {3'b0, max_to}) sum = {3'b0, max_to};
    rto_n = sum[15:0];
  end

  logic [16:0] dbl;
  assign dbl = {slot_timeout[best], 1'b0};

  // control registers: config, estimator, table flags, scan
  always_ff @(posedge clk) begin
    if (rst) begin
      max_to <= 16'd60000;
      max_retries <= 8'd10;
      max_in_flight <= 5'd16;
      srtt <= 16'd1000;
      rttvar <= 16'd500;
      rto <= 16'd1000;
      slot_valid <= '0;
      mark <= '0;
      next_sequence <= '0;
      idx <= '0;
      out_tvalid <= 1'b0;
      op <= hrt_pkg::OpSend;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          hrt_pkg::RegInitTimeout: begin
            srtt <= cfg_data;
            rttvar <= cfg_data >> 1;
            rto <= cfg_data;
          end
          hrt_pkg::RegMaxTimeout:  max_to <= cfg_data;
          hrt_pkg::RegMaxRetries:  max_retries <= cfg_data[7:0];
          default:                 max_in_flight <= cfg_data[4:0];
        endcase
      end
      if (cmd.load) begin
        op <= in_tdata[1:0];
        idx <= '0;
        mark <= '0;
      end
      if (cmd.scan) begin
        mark[ix] <= mark_i;
        idx <= st.scan_done ? '0 : idx + (IW+1)'(1);
      end
      if (cmd.pick) idx <= st.pick_done ? '0 : idx + (IW+1)'(1);
      if (cmd.apply) begin
        mark[best] <= 1'b0;
        if (op == hrt_pkg::OpAck) begin
          srtt <= srtt_n;
          rttvar <= var_n;
          rto <= rto_n;
        end
      end
      if (cmd.free) slot_valid <= slot_valid & ~mark_acked;
      if (cmd.send) begin
        next_sequence <= next_sequence + 32'd1;
        if (!is_ack && (seq_hit || free_found)) slot_valid[seq_hit ? hit_slot : free_slot] <= 1'b1;
      end
      // output valid: set on a new result, cleared once taken
      if (cmd.emit) out_tvalid <= 1'b1;
      else if (out_tvalid && out_tready) out_tvalid <= 1'b0;
    end
  end

  // payload registers: request, scan accumulators, slot contents
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      now <= in_tdata[33:2];
      is_ack <= in_tdata[34];
      rs <= in_tdata[66:35];
      re <= in_tdata[98:67];
      count <= '0;
      seq_hit <= 1'b0;
      free_found <= 1'b0;
      acked <= '0;
      mark_acked <= '0;
      hit_slot <= '0;
      free_slot <= '0;
    end
    if (cmd.scan) begin
      if (slot_valid[ix]) count <= count + CW'(1);
      if (slot_valid[ix] && slot_sequence[ix] == next_sequence && !seq_hit) begin
        seq_hit <= 1'b1;
        hit_slot <= ix;
      end
      if (!slot_valid[ix] && !free_found) begin
        free_found <= 1'b1;
        free_slot <= ix;
      end
    end
    // running minimum over marks, one slot per cycle
    if (cmd.pick) begin
      if (idx == '0) begin
        best_ok <= mark[ix];
        best <= ix;
      end else if (mark[ix] && (!best_ok || slot_sequence[ix] < slot_sequence[best])) begin
        best_ok <= 1'b1;
        best <= ix;
      end
    end
    if (cmd.scan) best_ok <= 1'b0;
    if (cmd.apply) begin
      if (op == hrt_pkg::OpAck) begin
        mark_acked[best] <= 1'b1;
        acked <= acked + 5'd1;
      end else begin
        slot_timeout[best] <= (dbl > {1'b0, max_to}) ? max_to : dbl[15:0];
        slot_sent_at[best] <= now;
        slot_retries[best] <= slot_retries[best] + 8'd1;
      end
    end
    if (cmd.send && !is_ack && (seq_hit || free_found)) begin
      slot_sequence[seq_hit ? hit_slot : free_slot] <= next_sequence;
      slot_sent_at[seq_hit ? hit_slot : free_slot] <= now;
      slot_timeout[seq_hit ? hit_slot : free_slot] <= rto;
      slot_retries[seq_hit ? hit_slot : free_slot] <= 8'd0;
    end
    // output register
    if (cmd.emit) begin
      out_tdata[2:0] <= cmd.kind;
      out_tdata[34:3] <= cmd.use_seq ? slot_sequence[best] :
                         (cmd.kind == hrt_pkg::KindSent) ? next_sequence : 32'd0;
      out_tdata[39:35] <= (cmd.kind == hrt_pkg::KindAckDone) ? acked : 5'd0;
      out_tdata[55:40] <= rto;
      out_tlast <= cmd.out_last;
    end
  end

endmodule

// File: src/handshake_retransmit_tracker_core.sv
// ---------------------------------------------------------------------------
// handshake_retransmit_tracker_core
// Retransmission tracker with an RFC 6298 style timeout estimator.
// ---------------------------------------------------------------------------
// Input stream s_axis carries one request: send, acknowledgement range or
// timeout check. Output stream m_axis carries results; tlast marks the final
// result of a request. A send gives one result, an ack range gives one
// result, a check gives one result per retransmitted slot and a closing one
// unless a slot is out of retries, which gives a final failed result; an
// unknown operation gives no result. A request is captured and the table
// scanned slot by slot; a send then loads its result. Ack and check requests
// do a sequential minimum search and an update per handled slot, a final
// search and update, a free step for an ack range and the final result.
// One request is worked on at a time; tready is high only when idle, so the
// next request is taken the cycle after the final result is loaded.
// The output is one register; a stalled receiver holds the controller until
// the pending result is taken. Reset empties the table, zeroes the sequence
// counter and loads the configuration defaults and the estimator.
// Configuration is written through cfg_we / cfg_index / cfg_data.
// ---------------------------------------------------------------------------
module handshake_retransmit_tracker_core #(
  parameter int TABLE_DEPTH = hrt_pkg::TableDepthDefault
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // operation[1:0], now_ms[33:2], is_ack_message[34], range_start[66:35],
  // range_end[98:67], zero fill
  input  logic [103:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // kind[2:0], sequence_res[34:3], acked_count[39:35], current_rto_ms[55:40]
  output logic [55:0]  m_axis_tdata,
  output logic         m_axis_tlast,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_data
);

  hrt_pkg::cmd_t    cmd;
  hrt_pkg::status_t st;

  hrt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .st       (st),
    .cmd      (cmd)
  );

  hrt_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .st         (st),
    .in_tdata   (s_axis_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (m_axis_tvalid),
    .out_tready (m_axis_tready),
    .out_tdata  (m_axis_tdata),
    .out_tlast  (m_axis_tlast)
  );

endmodule
